FILE: hdl/mutex_lock_with_wait_queues_top_defines.svh
// Assertion macros shared by the lock manager RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MUTEX_LOCK_WITH_WAIT_QUEUES_TOP_DEFINES_SVH
`define MUTEX_LOCK_WITH_WAIT_QUEUES_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MLWQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define MLWQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mlwq_pkg.sv
// Package for the lock manager: sizes, codes, structs and the ring helper.
// No dependencies; all other files but the assertion header refer to it by scoped names.
package mlwq_pkg;

  localparam int NUM_LOCKS   = 3;
  localparam int LOCK_W      = 2;
  localparam int QUEUE_DEPTH = 8;
  localparam int PID_WIDTH   = 4;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  typedef logic [PID_WIDTH-1:0] pid_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [LOCK_W-1:0]    lock_idx_t;

  typedef enum logic {
    CMD_WAIT   = 1'b0,
    CMD_SIGNAL = 1'b1
  } cmd_t;

  localparam lock_idx_t RES_USER_INPUT  = lock_idx_t'(0);
  localparam lock_idx_t RES_USER_OUTPUT = lock_idx_t'(1);
  localparam lock_idx_t RES_FILE        = lock_idx_t'(2);
  localparam lock_idx_t RES_UNKNOWN     = lock_idx_t'(3);

  typedef struct packed {
    cmd_t      command;
    lock_idx_t resource;
    pid_t      pid;
  } req_t;

  typedef struct packed {
    logic      enq;
    logic      deq;
    lock_idx_t lock;
    pid_t      pid;
  } q_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    pid_t head_pid;
  } q_stat_t;

  typedef struct packed {
    logic granted;
    logic blocked;
    logic dropped;
    logic woken_valid;
    pid_t woken_pid;
    logic owner_valid;
    pid_t owner_pid;
  } result_t;

  // Ring position head + offset; the sum stays below twice the depth.
  function automatic ptr_t ring_add(ptr_t head, cnt_t offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(offset);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return ptr_t'(sum);
  endfunction

endpackage

FILE: hdl/mlwq_in_if.sv
// Request channel interface: valid/ready handshake with the request fields.
// Depends on mlwq_pkg for the field widths.
interface mlwq_in_if;
  logic             valid;
  logic             ready;
  logic             command;
  logic [1:0]       resource;
  mlwq_pkg::pid_t   pid;

  modport source (output valid, command, resource, pid, input ready);
  modport sink   (input valid, command, resource, pid, output ready);
endinterface

FILE: hdl/mlwq_out_if.sv
// Result channel interface: valid/ready handshake with the result fields.
// Depends on mlwq_pkg for the field widths.
interface mlwq_out_if;
  logic           valid;
  logic           ready;
  logic           granted;
  logic           blocked;
  logic           dropped;
  logic           woken_valid;
  mlwq_pkg::pid_t woken_pid;
  logic           owner_valid;
  mlwq_pkg::pid_t owner_pid;

  modport source (output valid, granted, blocked, dropped, woken_valid, woken_pid,
                  owner_valid, owner_pid, input ready);
  modport sink   (input valid, granted, blocked, dropped, woken_valid, woken_pid,
                  owner_valid, owner_pid, output ready);
endinterface

FILE: hdl/mlwq_queue.sv
// Wait queues: one ring of process ids per lock with head pointer and count.
// Depends on mlwq_pkg.
module mlwq_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  mlwq_pkg::lock_idx_t sel,
  input  mlwq_pkg::q_cmd_t  cmd,
  output mlwq_pkg::q_stat_t stat
);

  mlwq_pkg::pid_t ids_r     [mlwq_pkg::NUM_LOCKS][mlwq_pkg::QUEUE_DEPTH];
  mlwq_pkg::ptr_t head_r    [mlwq_pkg::NUM_LOCKS];
  mlwq_pkg::ptr_t head_nxt  [mlwq_pkg::NUM_LOCKS];
  mlwq_pkg::cnt_t count_r   [mlwq_pkg::NUM_LOCKS];
  mlwq_pkg::cnt_t count_nxt [mlwq_pkg::NUM_LOCKS];

  // Status of the lock addressed by the request in flight.
  always_comb begin
    stat = '0;
    for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
      if (sel == mlwq_pkg::LOCK_W'(l)) begin
        stat.empty    = (count_r[l] == '0);
        stat.full     = (count_r[l] == mlwq_pkg::CNT_W'(mlwq_pkg::QUEUE_DEPTH));
        stat.head_pid = ids_r[l][head_r[l]];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
      head_nxt[l]  = head_r[l];
      count_nxt[l] = count_r[l];
      if (cmd.lock == mlwq_pkg::LOCK_W'(l)) begin
        if (cmd.enq) begin
          count_nxt[l] = count_r[l] + mlwq_pkg::CNT_W'(1);
        end else if (cmd.deq) begin
          head_nxt[l]  = mlwq_pkg::ring_add(head_r[l], mlwq_pkg::CNT_W'(1));
          count_nxt[l] = count_r[l] - mlwq_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
        head_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
        head_r[l]  <= head_nxt[l];
        count_r[l] <= count_nxt[l];
      end
    end
  end

  // Entries are written only by an enqueue and need no reset.
  always_ff @(posedge clk) begin
    for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
      if (cmd.enq && cmd.lock == mlwq_pkg::LOCK_W'(l)) begin
        ids_r[l][mlwq_pkg::ring_add(head_r[l], count_r[l])] <= cmd.pid;
      end
    end
  end

endmodule

FILE: hdl/mlwq_lock_ctrl.sv
// Owner registers and the decision logic for wait and signal requests.
// Depends on mlwq_pkg; drives the wait queues through a q_cmd_t struct.
module mlwq_lock_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  mlwq_pkg::req_t    req,
  input  mlwq_pkg::q_stat_t q_stat,
  output mlwq_pkg::q_cmd_t  q_cmd,
  output mlwq_pkg::result_t result
);

  logic           held_r     [mlwq_pkg::NUM_LOCKS];
  logic           held_nxt   [mlwq_pkg::NUM_LOCKS];
  mlwq_pkg::pid_t holder_r   [mlwq_pkg::NUM_LOCKS];
  mlwq_pkg::pid_t holder_nxt [mlwq_pkg::NUM_LOCKS];

  logic           known;
  logic           cur_held;
  logic           new_held;
  mlwq_pkg::pid_t new_holder;

  always_comb begin
    known    = (req.resource != mlwq_pkg::RES_UNKNOWN);
    cur_held = 1'b0;
    for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
      if (req.resource == mlwq_pkg::LOCK_W'(l)) begin
        cur_held = held_r[l];
      end
    end

    result     = '0;
    q_cmd      = '0;
    q_cmd.lock = req.resource;
    q_cmd.pid  = req.pid;
    new_held   = 1'b0;
    new_holder = '0;

    if (!known) begin
      result.granted = (req.command == mlwq_pkg::CMD_WAIT);
    end else begin
      case (req.command)
        mlwq_pkg::CMD_WAIT: begin
          if (!cur_held) begin
            result.granted = 1'b1;
            new_held       = 1'b1;
            new_holder     = req.pid;
          end else begin
            result.blocked = 1'b1;
            result.dropped = q_stat.full;
            q_cmd.enq      = fire && !q_stat.full;
            new_held       = 1'b1;
            for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
              if (req.resource == mlwq_pkg::LOCK_W'(l)) begin
                new_holder = holder_r[l];
              end
            end
          end
        end
        mlwq_pkg::CMD_SIGNAL: begin
          if (!q_stat.empty) begin
            q_cmd.deq          = fire;
            new_held           = 1'b1;
            new_holder         = q_stat.head_pid;
            result.woken_valid = 1'b1;
            result.woken_pid   = q_stat.head_pid;
          end
        end
        default: begin
          new_held = 1'b0;
        end
      endcase
      result.owner_valid = new_held;
      result.owner_pid   = new_held ? new_holder : '0;
    end

    for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
      held_nxt[l]   = held_r[l];
      holder_nxt[l] = holder_r[l];
      if (fire && known && req.resource == mlwq_pkg::LOCK_W'(l)) begin
        held_nxt[l]   = new_held;
        holder_nxt[l] = new_holder;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
        held_r[l]   <= 1'b0;
        holder_r[l] <= '0;
      end
    end else begin
      for (int l = 0; l < mlwq_pkg::NUM_LOCKS; l++) begin
        held_r[l]   <= held_nxt[l];
        holder_r[l] <= holder_nxt[l];
      end
    end
  end

endmodule

FILE: hdl/mutex_lock_with_wait_queues_top.sv
// Top level of the lock manager: request stage, result register, handshakes.
// Depends on mlwq_pkg, mlwq_in_if, mlwq_out_if, mlwq_queue, mlwq_lock_ctrl
// and the assertion macros in mutex_lock_with_wait_queues_top_defines.svh.
//
// Usage
// The block manages three locks (user input, user output, file). Each request
// transaction on in_chan carries a command (wait or signal), a resource and a
// process id; each one yields exactly one result transaction on out_chan.
// Resource code 3 is unrecognized: a wait on it grants and nothing changes, a
// signal on it returns an all-zero result.
// An accepted request is held in the request register while the lock decision
// and queue update are made in a single pass; it then retires into the result
// register once that register is free or its transaction is being taken.
// Throughput is one transaction per cycle while out_chan does not stall; the
// owner registers and queue pointers are updated at the same edge that loads
// the result, so a back-to-back request sees the new state.
// When out_chan stalls, the result register holds its transaction, the request
// register fills, and in_chan.ready drops only once both are occupied.
// Reset (rst_n low, synchronous) frees every lock, empties every wait queue
// and discards any transaction in flight. Queue entries are not cleared.
`include "mutex_lock_with_wait_queues_top_defines.svh"

module mutex_lock_with_wait_queues_top (
  input logic       clk,
  input logic       rst_n,
  mlwq_in_if.sink   in_chan,
  mlwq_out_if.source out_chan
);

  // Request stage.
  logic              req_v_r;
  mlwq_pkg::req_t    req_r;
  // Result stage.
  logic              res_v_r;
  mlwq_pkg::result_t res_r;

  logic              advance;
  logic              in_fire;
  mlwq_pkg::q_cmd_t  q_cmd;
  mlwq_pkg::q_stat_t q_stat;
  mlwq_pkg::result_t result;

  // The request in the stage retires when the result register is free or
  // its current transaction is being taken this cycle.
  assign advance       = req_v_r && (!res_v_r || out_chan.ready);
  assign in_chan.ready = !req_v_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      req_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.command  <= mlwq_pkg::cmd_t'(in_chan.command);
      req_r.resource <= in_chan.resource;
      req_r.pid      <= in_chan.pid;
    end
  end

  mlwq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .sel   (req_r.resource),
    .cmd   (q_cmd),
    .stat  (q_stat)
  );

  // State changes only when the request actually retires into the result.
  mlwq_lock_ctrl u_lock_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .req    (req_r),
    .q_stat (q_stat),
    .q_cmd  (q_cmd),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (advance) begin
      res_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_chan.valid       = res_v_r;
  assign out_chan.granted     = res_r.granted;
  assign out_chan.blocked     = res_r.blocked;
  assign out_chan.dropped     = res_r.dropped;
  assign out_chan.woken_valid = res_r.woken_valid;
  assign out_chan.woken_pid   = res_r.woken_pid;
  assign out_chan.owner_valid = res_r.owner_valid;
  assign out_chan.owner_pid   = res_r.owner_pid;

  // A woken process must be the owner reported in the same result.
  `MLWQ_ASSERT_IMP(a_woken_is_owner, res_v_r && res_r.woken_valid,
    res_r.owner_valid && res_r.owner_pid == res_r.woken_pid, "woken pid is not the owner")
  // A dropped requester was always a blocked one.
  `MLWQ_ASSERT_IMP(a_drop_implies_block, res_v_r && res_r.dropped,
    res_r.blocked && !res_r.granted, "dropped without blocked")
  // Blocking only happens on a lock that stays held.
  `MLWQ_ASSERT_IMP(a_block_keeps_owner, res_v_r && res_r.blocked,
    res_r.owner_valid && !res_r.woken_valid, "blocked on a free lock")
  // A retiring request always produces a valid result on the next cycle.
  `MLWQ_ASSERT(a_retire_to_result, advance |=> res_v_r, "retired request lost")

endmodule
